// ----- src/csl_pkg.sv -----
// ----------------------------------------------------------------------------
// csl_pkg
// Shared constants, types and helpers of the contention-set LRU cache model.
// ----------------------------------------------------------------------------
package csl_pkg;

  localparam int ADDR_BITS        = 48;
  localparam int LINE_OFFSET_BITS = 6;
  localparam int PAGE_OFFSET_BITS = 12;
  localparam int NUM_SETS         = 16;
  localparam int MAX_WAYS         = 16;

  localparam int NUM_LINES  = 1 << (PAGE_OFFSET_BITS - LINE_OFFSET_BITS);
  localparam int LINE_W     = PAGE_OFFSET_BITS - LINE_OFFSET_BITS;
  localparam int TAG_W      = ADDR_BITS - LINE_OFFSET_BITS;
  localparam int CLK_W      = 48;
  localparam int WAY_W      = $clog2(MAX_WAYS);
  localparam int GRP_W      = $clog2(NUM_SETS + 2);
  localparam int ENTRY_W    = GRP_W + WAY_W;
  localparam int NUM_ENTRY  = (NUM_SETS + 1) * MAX_WAYS;
  localparam int CNT_W      = $clog2(MAX_WAYS + 1);
  localparam int SIDX_W     = $clog2(NUM_SETS);

  localparam logic [1:0] FUNC_ACCESS = 2'd0;
  localparam logic [1:0] FUNC_MASK   = 2'd1;
  localparam logic [1:0] FUNC_ASSOC  = 2'd2;

  localparam logic [2:0] ADDR_WB    = 3'd0;
  localparam logic [2:0] ADDR_DWAYS = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MASK,
    ST_NEXTSET,
    ST_SCAN,
    ST_TAIL,
    ST_APPLY,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic mask_init;
    logic grp_inc;
    logic scan_start;
    logic issue;
    logic apply;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       set_sel;
    logic       grp_done;
    logic       way_last;
  } status_t;

  typedef struct packed {
    logic       write_back;
    logic [4:0] default_ways;
  } cfg_t;

  function automatic logic [CNT_W-1:0] clamp_ways(input logic [4:0] w);
    logic [CNT_W-1:0] r;
    if (w == 5'd0) r = CNT_W'(1);
    else if (32'(w) > MAX_WAYS) r = CNT_W'(MAX_WAYS);
    else r = CNT_W'(w);
    return r;
  endfunction

endpackage

// ----- src/csl_ctrl.sv -----
// ----------------------------------------------------------------------------
// csl_ctrl
// Sequencer: accepts a transaction, walks the selected sets way by way and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module csl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  csl_pkg::status_t  status,
  output csl_pkg::cmd_t     cmd
);

  csl_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= csl_pkg::ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      csl_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept = 1'b1;
          if (status.func == csl_pkg::FUNC_ACCESS) state_next = csl_pkg::ST_MASK;
          else state_next = csl_pkg::ST_FINISH;
        end
      end
      csl_pkg::ST_MASK: begin
        cmd.mask_init = 1'b1;
        state_next    = csl_pkg::ST_NEXTSET;
      end
      csl_pkg::ST_NEXTSET: begin
        if (status.grp_done) begin
          state_next = csl_pkg::ST_FINISH;
        end else if (status.set_sel) begin
          cmd.scan_start = 1'b1;
          state_next     = csl_pkg::ST_SCAN;
        end else begin
          cmd.grp_inc = 1'b1;
        end
      end
      csl_pkg::ST_SCAN: begin
        cmd.issue = 1'b1;
        if (status.way_last) state_next = csl_pkg::ST_TAIL;
      end
      csl_pkg::ST_TAIL: begin
        state_next = csl_pkg::ST_APPLY;
      end
      csl_pkg::ST_APPLY: begin
        cmd.apply   = 1'b1;
        cmd.grp_inc = 1'b1;
        state_next  = csl_pkg::ST_NEXTSET;
      end
      csl_pkg::ST_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.finish = 1'b1;
          state_next = csl_pkg::ST_IDLE;
        end
      end
      default: state_next = csl_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- src/csl_datapath.sv -----
// ----------------------------------------------------------------------------
// csl_datapath
// Tag and use-time stores, membership table, associativity table, way scan
// accumulators and result register.
// ----------------------------------------------------------------------------
module csl_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  csl_pkg::cmd_t                    cmd,
  input  csl_pkg::cfg_t                    cfg,
  output csl_pkg::status_t                 status,
  input  logic [1:0]                       func,
  input  logic [csl_pkg::ADDR_BITS-1:0]    address,
  input  logic                             is_write,
  input  logic [5:0]                       line_index,
  input  logic [15:0]                      set_mask,
  input  logic [3:0]                       set_index,
  input  logic [4:0]                       ways,
  output logic                             miss,
  output logic                             dirty_eviction
);

  localparam int TW = csl_pkg::TAG_W;
  localparam int CW = csl_pkg::CLK_W;
  localparam int WW = csl_pkg::WAY_W;
  localparam int GW = csl_pkg::GRP_W;
  localparam int EW = csl_pkg::ENTRY_W;
  localparam int NW = csl_pkg::CNT_W;
  localparam int NS = csl_pkg::NUM_SETS;
  localparam int LINE_W_L = csl_pkg::LINE_W;

  logic [TW-1:0] tag_mem   [csl_pkg::NUM_ENTRY];
  logic [CW-1:0] time_mem  [csl_pkg::NUM_ENTRY];
  logic          dirty_mem [csl_pkg::NUM_ENTRY];
  logic [NS-1:0] mask_mem  [csl_pkg::NUM_LINES];
  logic [csl_pkg::NUM_LINES-1:0] mask_vld;
  logic [csl_pkg::NUM_ENTRY-1:0] entry_valid;
  logic [4:0] assoc [NS];

  logic [1:0]      func_r;
  logic [TW-1:0]   tag_r;
  logic            wr_r;
  logic [CW-1:0]   access_clock;
  logic [NS-1:0]   mask_q;
  logic            mask_vq;
  logic [NS-1:0]   mask_r;
  logic            dflt;
  logic [GW-1:0]   grp;
  logic [WW-1:0]   way;
  logic            rd_vld;
  logic [WW-1:0]   rd_way;
  logic [TW-1:0]   tag_q;
  logic [CW-1:0]   time_q;
  logic            dirty_q;
  logic            valid_q;
  logic            hit;
  logic [WW-1:0]   hit_way;
  logic [NW-1:0]   count;
  logic            free_found;
  logic [WW-1:0]   free_way;
  logic            lru_found;
  logic [WW-1:0]   lru_way;
  logic [CW-1:0]   lru_time;
  logic            lru_dirty;
  logic            stopped;
  logic            dirty_ev;

  logic [TW-1:0]   acc_tag;
  logic [LINE_W_L-1:0] acc_line;
  logic [EW-1:0]   rd_idx;
  logic [NW-1:0]   grp_ways;
  logic            evict;
  logic [WW-1:0]   slot;
  logic [EW-1:0]   slot_idx;
  logic [EW-1:0]   hit_idx;

  assign acc_tag  = address[csl_pkg::ADDR_BITS-1:csl_pkg::LINE_OFFSET_BITS];
  assign acc_line = acc_tag[LINE_W_L-1:0];
  assign rd_idx   = {grp, way};
  assign hit_idx  = {grp, hit_way};

  always_comb begin
    if (grp == GW'(NS)) grp_ways = csl_pkg::clamp_ways(cfg.default_ways);
    else grp_ways = csl_pkg::clamp_ways(assoc[grp[csl_pkg::SIDX_W-1:0]]);
    evict = (count >= grp_ways) && lru_found;
    if (evict) slot = lru_way;
    else if (free_found) slot = free_way;
    else slot = lru_way;
    slot_idx = {grp, slot};
  end

  always_comb begin
    status.func     = func;
    status.way_last = (way == WW'(csl_pkg::MAX_WAYS - 1));
    status.grp_done = (grp == GW'(NS) && !dflt) || grp == GW'(NS + 1);
    if (grp == GW'(NS)) status.set_sel = dflt;
    else if (grp < GW'(NS)) status.set_sel = mask_r[grp[csl_pkg::SIDX_W-1:0]];
    else status.set_sel = 1'b0;
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.accept && func == csl_pkg::FUNC_MASK)
      mask_mem[line_index[LINE_W_L-1:0]] <= set_mask[NS-1:0];
    mask_q  <= mask_mem[acc_line];
    tag_q   <= tag_mem[rd_idx];
    time_q  <= time_mem[rd_idx];
    dirty_q <= dirty_mem[rd_idx];
    valid_q <= entry_valid[rd_idx];
    if (cmd.apply && hit) begin
      time_mem[hit_idx] <= access_clock;
      if (wr_r) dirty_mem[hit_idx] <= cfg.write_back;
    end else if (cmd.apply) begin
      time_mem[slot_idx]  <= access_clock;
      tag_mem[slot_idx]   <= tag_r;
      dirty_mem[slot_idx] <= wr_r && cfg.write_back;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_vld     <= '0;
      entry_valid  <= '0;
      access_clock <= '0;
      for (int i = 0; i < NS; i++) assoc[i] <= 5'd16;
    end else begin
      if (cmd.accept) begin
        unique case (func)
          csl_pkg::FUNC_ACCESS: access_clock <= access_clock + CW'(1);
          csl_pkg::FUNC_MASK:   mask_vld[line_index[LINE_W_L-1:0]] <= 1'b1;
          csl_pkg::FUNC_ASSOC: begin
            if (32'(set_index) < NS) assoc[set_index[csl_pkg::SIDX_W-1:0]] <= ways;
          end
          default: ;
        endcase
      end
      if (cmd.apply && !hit) entry_valid[slot_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r   <= func;
      tag_r    <= acc_tag;
      wr_r     <= is_write;
      stopped  <= 1'b0;
      dirty_ev <= 1'b0;
      mask_vq  <= mask_vld[acc_line];
    end
    if (cmd.mask_init) begin
      mask_r <= mask_vq ? mask_q : '0;
      dflt   <= !mask_vq || mask_q == '0;
      grp    <= (!mask_vq || mask_q == '0) ? GW'(NS) : '0;
    end else if (cmd.grp_inc) begin
      grp <= grp + GW'(1);
    end
    if (cmd.scan_start) begin
      way        <= '0;
      hit        <= 1'b0;
      count      <= '0;
      free_found <= 1'b0;
      lru_found  <= 1'b0;
    end else if (cmd.issue) begin
      way <= way + WW'(1);
    end
    rd_vld <= cmd.issue;
    rd_way <= way;
    if (rd_vld) begin
      if (valid_q) begin
        count <= count + NW'(1);
        if (tag_q == tag_r) begin
          hit     <= 1'b1;
          hit_way <= rd_way;
        end
        if (!lru_found || time_q < lru_time) begin
          lru_found <= 1'b1;
          lru_way   <= rd_way;
          lru_time  <= time_q;
          lru_dirty <= dirty_q;
        end
      end else if (!free_found) begin
        free_found <= 1'b1;
        free_way   <= rd_way;
      end
    end
    if (cmd.apply) begin
      if (hit) begin
        if (!(wr_r && !cfg.write_back)) stopped <= 1'b1;
      end else if (evict && lru_dirty) begin
        dirty_ev <= 1'b1;
      end
    end
    if (cmd.finish) begin
      miss           <= (func_r == csl_pkg::FUNC_ACCESS) && !stopped;
      dirty_eviction <= (func_r == csl_pkg::FUNC_ACCESS) && dirty_ev;
    end
  end

endmodule

// ----- src/contention_set_lru_cache_model.sv -----
// ----------------------------------------------------------------------------
// contention_set_lru_cache_model
// LRU cache model over contention sets with a default set.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_ready) carries one transaction: a memory
// access, a membership mask load or a set associativity load. Response
// channel (rsp_valid/rsp_ready) returns miss and dirty_eviction, one
// response per request, in order.
// A load or an unknown function answers without a set walk. An access walks
// the default set when no contention set is selected, otherwise each
// selected contention set in turn, reading the tag and use-time stores
// one way per cycle. One transaction is in flight at a time and the next
// request can be accepted in the cycle after the response is produced.
// Reset clears valid bits, the membership table, the access clock and
// sets all associativities to 16, write-back on, default set 16 ways.
// When the receiver stalls, the output register holds its response and a
// finished transaction waits in the sequencer until that response leaves.
// Configuration: APB, 0x0 write_back_mode, 0x4 default_set_ways.
// ----------------------------------------------------------------------------
module contention_set_lru_cache_model (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [1:0]                    func,
  input  logic [csl_pkg::ADDR_BITS-1:0] address,
  input  logic                          is_write,
  input  logic [5:0]                    line_index,
  input  logic [15:0]                   set_mask,
  input  logic [3:0]                    set_index,
  input  logic [4:0]                    ways,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic                          miss,
  output logic                          dirty_eviction
);

  csl_pkg::cfg_t    cfg;
  csl_pkg::cmd_t    cmd;
  csl_pkg::status_t status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.write_back   <= 1'b1;
      cfg.default_ways <= 5'd16;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr == csl_pkg::ADDR_WB) cfg.write_back <= pwdata[0];
      else if (paddr == csl_pkg::ADDR_DWAYS) cfg.default_ways <= pwdata[4:0];
    end
  end

  always_comb begin
    if (paddr == csl_pkg::ADDR_WB) prdata = {31'd0, cfg.write_back};
    else if (paddr == csl_pkg::ADDR_DWAYS) prdata = {27'd0, cfg.default_ways};
    else prdata = '0;
  end

  csl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .status    (status),
    .cmd       (cmd)
  );

  csl_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg            (cfg),
    .status         (status),
    .func           (func),
    .address        (address),
    .is_write       (is_write),
    .line_index     (line_index),
    .set_mask       (set_mask),
    .set_index      (set_index),
    .ways           (ways),
    .miss           (miss),
    .dirty_eviction (dirty_eviction)
  );

endmodule
